// File: hdl/bilinear_rgb_sampler_defines.svh
// Assertion macros for the bilinear RGB sampler
`ifndef BILINEAR_RGB_SAMPLER_DEFINES_SVH
`define BILINEAR_RGB_SAMPLER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define BRS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define BRS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: hdl/brs_pkg.sv
// Shared constants, codes and pixel type of the bilinear RGB sampler
package brs_pkg;

  // Default sizes of the pixel store and of the coordinate fraction
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int FRAC_BITS_DEF  = 8;

  // Fixed field widths
  localparam int COORD_W   = 17;
  localparam int POS_W     = 9;
  localparam int CHAN_W    = 8;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  // wide enough for any image size up to 4096
  localparam int SIZE_W    = 13;

  localparam logic [CFG_W-1:0] SIZE_RESET = 10'd512;

  // Item operations
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // One stored pixel: blue in the low byte, red in the high byte
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  localparam int PIX_W = $bits(pixel_t);

endpackage

// File: hdl/brs_pixel_mem.sv
// Pixel store with separate write and read ports: one write and one registered read per cycle
module brs_pixel_mem #(
  parameter int AW = 18,
  parameter int DW = brs_pkg::PIX_W
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  localparam int DEPTH = 2 ** AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/brs_blend.sv
// Three-stage bilinear blend of four pixels, round to nearest, ties to even
module brs_blend #(
  parameter int FRAC_BITS = brs_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  brs_pkg::pixel_t      p00,
  input  brs_pkg::pixel_t      p01,
  input  brs_pkg::pixel_t      p10,
  input  brs_pkg::pixel_t      p11,
  input  logic [FRAC_BITS-1:0] frac_x,
  input  logic [FRAC_BITS-1:0] frac_y,
  output logic                 done,
  output brs_pkg::pixel_t      result
);

  localparam int CW = brs_pkg::CHAN_W;
  localparam int SW = FRAC_BITS + 1;         // weight, up to 1.0
  localparam int MW = CW + SW;               // pixel times weight
  localparam int TW = CW + FRAC_BITS;        // row blend, below 256.0
  localparam int VW = CW + 2 * FRAC_BITS;    // full blend
  localparam int QW = CW + 1;                // rounded value with carry
  localparam logic [SW-1:0] ONE = SW'(1) << FRAC_BITS;

  logic [2:0][CW-1:0] c00, c01, c10, c11;

  logic [SW-1:0] wx0, wx1, wy0, wy1;
  logic [FRAC_BITS-1:0] fy_r;

  logic [MW-1:0] m00_nxt [3];
  logic [MW-1:0] m01_nxt [3];
  logic [MW-1:0] m10_nxt [3];
  logic [MW-1:0] m11_nxt [3];
  logic [MW-1:0] m00_r [3];
  logic [MW-1:0] m01_r [3];
  logic [MW-1:0] m10_r [3];
  logic [MW-1:0] m11_r [3];

  logic [TW-1:0] top [3];
  logic [TW-1:0] bot [3];
  logic [VW-1:0] v0_nxt [3];
  logic [VW-1:0] v1_nxt [3];
  logic [VW-1:0] v0_r [3];
  logic [VW-1:0] v1_r [3];

  logic [VW-1:0]        sum  [3];
  logic [CW-1:0]        quo  [3];
  logic [2*FRAC_BITS-1:0] rem [3];
  logic                 rnd  [3];
  logic [QW-1:0]        qn   [3];
  logic [2:0][CW-1:0]   res_nxt, res_r;

  logic s1_vld_r, s2_vld_r, done_r;

  assign c00 = p00;
  assign c01 = p01;
  assign c10 = p10;
  assign c11 = p11;

  // Horizontal and vertical weights
  assign wx1 = {1'b0, frac_x};
  assign wx0 = ONE - wx1;
  assign wy1 = {1'b0, fy_r};
  assign wy0 = ONE - wy1;

  // Stage 1: each pixel times its horizontal weight
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      m00_nxt[ch] = MW'(c00[ch]) * MW'(wx0);
      m01_nxt[ch] = MW'(c01[ch]) * MW'(wx1);
      m10_nxt[ch] = MW'(c10[ch]) * MW'(wx0);
      m11_nxt[ch] = MW'(c11[ch]) * MW'(wx1);
    end
  end

  // Stage 2: row sums times vertical weight
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      top[ch]    = TW'(m00_r[ch] + m01_r[ch]);
      bot[ch]    = TW'(m10_r[ch] + m11_r[ch]);
      v0_nxt[ch] = VW'(top[ch]) * VW'(wy0);
      v1_nxt[ch] = VW'(bot[ch]) * VW'(wy1);
    end
  end

  // Stage 3: final sum, drop 2*FRAC_BITS fraction bits, ties go to even, saturate on carry
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = v0_r[ch] + v1_r[ch];
      quo[ch] = sum[ch][VW-1:2*FRAC_BITS];
      rem[ch] = sum[ch][2*FRAC_BITS-1:0];
      rnd[ch] = rem[ch][2*FRAC_BITS-1] &&
                ((|rem[ch][2*FRAC_BITS-2:0]) || quo[ch][0]);
      qn[ch]  = QW'(quo[ch]) + QW'(rnd[ch]);
      res_nxt[ch] = qn[ch][CW] ? {CW{1'b1}} : qn[ch][CW-1:0];
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      s1_vld_r <= start;
      s2_vld_r <= s1_vld_r;
      done_r   <= s2_vld_r;
    end
  end

  // Stage data; the result holds until the next blend finishes
  always_ff @(posedge clk) begin
    if (start) begin
      fy_r  <= frac_y;
      m00_r <= m00_nxt;
      m01_r <= m01_nxt;
      m10_r <= m10_nxt;
      m11_r <= m11_nxt;
    end
    if (s1_vld_r) begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
    if (s2_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// File: hdl/bilinear_rgb_sampler.sv
// Bilinear RGB888 sampler: pixel store, four-read fetch sequencer and blend.
// Write transfer: stored at the accepting edge, one write accepted per cycle while idle.
// Sample transfer: result valid after 4 reads on the single store read port (the
// last read feeding the blend), 3 blend stages and 1 output reg; the next item is
// accepted once the result is loaded, later while an older result waits.
// Synchronous active-low reset clears control, sets both sizes to 512; store kept.
module bilinear_rgb_sampler #(
  parameter int MAX_WIDTH  = brs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = brs_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = brs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [brs_pkg::POS_W-1:0]     in_write_col,
  input  logic [brs_pkg::POS_W-1:0]     in_write_row,
  input  logic [brs_pkg::CHAN_W-1:0]    in_blue_in,
  input  logic [brs_pkg::CHAN_W-1:0]    in_green_in,
  input  logic [brs_pkg::CHAN_W-1:0]    in_red_in,
  input  logic [brs_pkg::COORD_W-1:0]   in_sample_x,
  input  logic [brs_pkg::COORD_W-1:0]   in_sample_y,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [brs_pkg::CHAN_W-1:0]    out_blue_out,
  output logic [brs_pkg::CHAN_W-1:0]    out_green_out,
  output logic [brs_pkg::CHAN_W-1:0]    out_red_out,
  output logic                          out_range_flag,

  input  logic                          cfg_we,
  input  logic [brs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brs_pkg::CFG_W-1:0]     cfg_data
);

  `include "bilinear_rgb_sampler_defines.svh"

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = CW + RW;
  localparam int SZ = brs_pkg::SIZE_W;
  localparam logic [SZ-1:0] MAX_W_S = SZ'(MAX_WIDTH);
  localparam logic [SZ-1:0] MAX_H_S = SZ'(MAX_HEIGHT);
  // neighbour order: bit 1 selects the lower row, bit 0 the right column
  localparam logic [1:0] NB_LAST = 2'b11;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WAIT, S_HOLD} state_t;

  typedef struct packed {
    logic [SZ-1:0]        i0;
    logic [SZ-1:0]        i1;
    logic [FRAC_BITS-1:0] f;
    logic                 over;
  } axis_t;

  // Clamp a size register to 1..maxv
  function automatic logic [SZ-1:0] clamp_size(input logic [brs_pkg::CFG_W-1:0] v,
                                               input logic [SZ-1:0] maxv);
    logic [SZ-1:0] ve;
    ve = SZ'(v);
    if (ve == '0) begin
      return SZ'(1);
    end
    return (ve > maxv) ? maxv : ve;
  endfunction

  // Split one coordinate, clamp it to the image and find its reflect-101 neighbour
  function automatic axis_t axis_decode(input logic [brs_pkg::COORD_W-1:0] coord,
                                        input logic [SZ-1:0] size);
    logic [SZ-1:0] ip, is, inx;
    logic ov;
    axis_t r;
    ip = SZ'(coord >> FRAC_BITS);
    ov = (ip >= size);
    is = ov ? size - SZ'(1) : ip;
    inx = is + SZ'(1);
    r.i0 = is;
    r.over = ov;
    r.f = ov ? '0 : coord[FRAC_BITS-1:0];
    r.i1 = (inx < size) ? inx : ((size >= SZ'(2)) ? size - SZ'(2) : '0);
    return r;
  endfunction

  logic [brs_pkg::CFG_W-1:0] width_r, height_r;
  logic [SZ-1:0]             size_w, size_h;
  axis_t                     ax, ay;

  state_t state_r, state_nxt;
  logic [1:0] rd_cnt_r, rd_cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  brs_pkg::pixel_t out_pix_r;
  logic out_flag_r;
  logic load_out, out_free;

  logic in_xfer, sample_xfer;
  logic [SZ-1:0] wr_col, wr_row;
  logic          wr_ok;
  logic          mem_we, rd_en;
  logic [AW-1:0] mem_wa, rd_addr;
  brs_pkg::pixel_t mem_wd, rd_data;

  logic [CW-1:0]        col0_r, col1_r;
  logic [RW-1:0]        row0_r, row1_r;
  logic [FRAC_BITS-1:0] frac_x_r, frac_y_r;
  logic                 flag_r;

  logic            tag_vld_r;
  logic [1:0]      tag_r;
  brs_pkg::pixel_t pix_r [3];
  logic            blend_start, blend_done;
  brs_pkg::pixel_t blend_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= brs_pkg::SIZE_RESET;
      height_r <= brs_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brs_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        brs_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign size_w = clamp_size(width_r, MAX_W_S);
  assign size_h = clamp_size(height_r, MAX_H_S);

  // Input transfers
  assign in_ready    = (state_r == S_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign sample_xfer = in_xfer && (in_operation == brs_pkg::OP_SAMPLE);

  // Pixel writes outside the store are dropped
  assign wr_col = SZ'(in_write_col);
  assign wr_row = SZ'(in_write_row);
  assign wr_ok  = (wr_col < MAX_W_S) && (wr_row < MAX_H_S);
  assign mem_we = in_xfer && (in_operation == brs_pkg::OP_WRITE) && wr_ok;
  assign mem_wa = {wr_row[RW-1:0], wr_col[CW-1:0]};
  assign mem_wd = '{red: in_red_in, green: in_green_in, blue: in_blue_in};

  // Coordinate decode, captured at the sample transfer
  assign ax = axis_decode(in_sample_x, size_w);
  assign ay = axis_decode(in_sample_y, size_h);

  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      col0_r   <= CW'(ax.i0);
      col1_r   <= CW'(ax.i1);
      row0_r   <= RW'(ay.i0);
      row1_r   <= RW'(ay.i1);
      frac_x_r <= ax.f;
      frac_y_r <= ay.f;
      flag_r   <= ax.over || ay.over;
    end
  end

  // Neighbour fetch address
  assign rd_en   = (state_r == S_READ);
  assign rd_addr = {rd_cnt_r[1] ? row1_r : row0_r, rd_cnt_r[0] ? col1_r : col0_r};

  brs_pixel_mem #(
    .AW (AW),
    .DW (brs_pkg::PIX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Tag each read so its data lands in the right neighbour slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_vld_r <= 1'b0;
    end else begin
      tag_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= rd_cnt_r;
    if (tag_vld_r && (tag_r != NB_LAST)) begin
      pix_r[tag_r] <= rd_data;
    end
  end

  // The last neighbour goes straight from the store into the blend
  assign blend_start = tag_vld_r && (tag_r == NB_LAST);

  brs_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (blend_start),
    .p00    (pix_r[0]),
    .p01    (pix_r[1]),
    .p10    (pix_r[2]),
    .p11    (rd_data),
    .frac_x (frac_x_r),
    .frac_y (frac_y_r),
    .done   (blend_done),
    .result (blend_res)
  );

  // Sequencer next state
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    load_out   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (sample_xfer) begin
          state_nxt  = S_READ;
          rd_cnt_nxt = '0;
        end
      end
      S_READ: begin
        rd_cnt_nxt = rd_cnt_r + 2'd1;
        if (rd_cnt_r == NB_LAST) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (blend_done) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load_out) begin
      out_pix_r  <= blend_res;
      out_flag_r <= flag_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_blue_out   = out_pix_r.blue;
  assign out_green_out  = out_pix_r.green;
  assign out_red_out    = out_pix_r.red;
  assign out_range_flag = out_flag_r;

  // Checks
  `BRS_ASSERT_IMP(a_done_in_wait, blend_done, state_r == S_WAIT)
  `BRS_ASSERT_IMP(a_start_after_reads, blend_start, $past(state_r) == S_READ && $past(rd_cnt_r) == NB_LAST)
  `BRS_ASSERT_IMP(a_hold_out_busy, state_r == S_HOLD, out_valid_r)
  `BRS_ASSERT_NEXT(a_load_shows, load_out, out_valid_r && state_r == S_IDLE)

endmodule
